>>> rtl/llsg_pkg.sv
// Package for the login lockout and session guard.
// Holds the shared types, reset values and codes used by every module.
// No dependencies.
`default_nettype none

package llsg_pkg;

   // Reset values of the configuration registers
   localparam logic [7:0]  RST_MAX_FAILED   = 8'd5;
   localparam logic [31:0] RST_BASE_LOCKOUT = 32'd30000;
   localparam logic [7:0]  RST_GROWTH       = 8'd3;
   localparam logic [31:0] RST_MIN_GAP      = 32'd1000;
   localparam logic [31:0] RST_SESSION_TMO  = 32'd300000;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REM_W      = 23;

   // Exact unsigned divide by 1000 for 32-bit values: (x * MULT) >> SHIFT
   localparam logic [28:0] DIV1000_MULT  = 29'd274877907;
   localparam int          DIV1000_SHIFT = 38;

   localparam logic [7:0] FAIL_SAT = 8'hFF;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAX_FAILED   = 3'd0,
      CSR_BASE_LOCKOUT = 3'd1,
      CSR_GROWTH       = 3'd2,
      CSR_MIN_GAP      = 3'd3,
      CSR_SESSION_TMO  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOGIN  = 2'd0,
      OP_LOGOUT = 2'd1,
      OP_STATUS = 2'd2,
      OP_ACCESS = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_RATE    = 3'd1,
      ST_LOCKED  = 3'd2,
      ST_BADPASS = 3'd3,
      ST_NOAUTH  = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0]  max_failed;
      logic [31:0] base_lockout;
      logic [7:0]  growth;
      logic [31:0] min_gap;
      logic [31:0] session_tmo;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic [31:0] client_id;
      logic        password_ok;
   } req_type;

   // Result of the decision stage, lockout time still in milliseconds
   typedef struct packed {
      status_type  status;
      logic        authenticated;
      logic        locked;
      logic [31:0] left_ms;
      logic [7:0]  failed_attempts;
      logic        lockout_began;
   } decision_type;

endpackage

`default_nettype wire

>>> rtl/llsg_csr.sv
// Configuration register file of the login guard.
// Depends on llsg_pkg for register indexes and reset values.
`default_nettype none

module llsg_csr
   import llsg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   // Write the addressed register; ignore unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_failed   <= RST_MAX_FAILED;
         cfg_ff.base_lockout <= RST_BASE_LOCKOUT;
         cfg_ff.growth       <= RST_GROWTH;
         cfg_ff.min_gap      <= RST_MIN_GAP;
         cfg_ff.session_tmo  <= RST_SESSION_TMO;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MAX_FAILED:   cfg_ff.max_failed   <= csr_wdata[7:0];
            CSR_BASE_LOCKOUT: cfg_ff.base_lockout <= csr_wdata;
            CSR_GROWTH:       cfg_ff.growth       <= csr_wdata[7:0];
            CSR_MIN_GAP:      cfg_ff.min_gap      <= csr_wdata;
            CSR_SESSION_TMO:  cfg_ff.session_tmo  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/llsg_core.sv
// Decision stage of the login guard: lockout, rate and session state.
// Updates the guard state once per transaction and registers the decision.
// Depends on llsg_pkg.
`default_nettype none

module llsg_core
   import llsg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    in_valid,
   input  wire req_type in_req,
   output logic         in_ready,
   output logic         dec_valid,
   output decision_type dec,
   input  wire logic    dec_ready
);

   // Guard state
   logic [7:0]  fail_count_ff,    fail_count_in;
   logic [31:0] lock_start_ff,    lock_start_in;
   logic [31:0] lock_span_ff,     lock_span_in;
   logic        lock_valid_ff,    lock_valid_in;
   logic [31:0] lockout_length_ff, lockout_length_in;
   logic [31:0] last_login_ff,    last_login_in;
   logic [31:0] session_client_ff, session_client_in;
   logic [31:0] last_activity_ff, last_activity_in;

   // Decision register
   logic         dec_valid_ff;
   decision_type dec_ff, dec_in;

   logic        take;
   logic [31:0] elapsed, left_cur, since_login, idle_time;
   logic        in_force, rate_hit, match, live, lock_expired;
   logic [39:0] grown;
   logic [31:0] grown_sat;
   logic [7:0]  fc_base, fc_inc;
   logic        trip;

   assign in_ready = !dec_valid_ff || dec_ready;
   assign take     = in_valid && in_ready;

   // Lockout observation at the event time
   always_comb begin
      elapsed      = in_req.now_ms - lock_start_ff;
      in_force     = lock_valid_ff && (elapsed < lock_span_ff);
      left_cur     = in_force ? (lock_span_ff - elapsed) : 32'd0;
      lock_expired = lock_valid_ff && !in_force;
      since_login  = in_req.now_ms - last_login_ff;
      rate_hit     = since_login < cfg.min_gap;
      idle_time    = in_req.now_ms - last_activity_ff;
      match        = (in_req.client_id != 32'd0) && (in_req.client_id == session_client_ff);
      live         = match && (idle_time < cfg.session_tmo);
      grown        = {8'd0, lockout_length_ff} * {32'd0, cfg.growth};
      grown_sat    = (grown[39:32] != 8'd0) ? 32'hFFFF_FFFF : grown[31:0];
      fc_base      = lock_expired ? 8'd0 : fail_count_ff;
      fc_inc       = (fc_base == FAIL_SAT) ? fc_base : fc_base + 8'd1;
      trip         = fc_inc >= cfg.max_failed;
   end

   // Next state and decision for the event in the input register
   always_comb begin
      fail_count_in     = fail_count_ff;
      lock_start_in     = lock_start_ff;
      lock_span_in      = lock_span_ff;
      lock_valid_in     = lock_valid_ff;
      lockout_length_in = lockout_length_ff;
      last_login_in     = last_login_ff;
      session_client_in = session_client_ff;
      last_activity_in  = last_activity_ff;

      dec_in.status          = ST_OK;
      dec_in.authenticated   = 1'b0;
      dec_in.lockout_began   = 1'b0;
      dec_in.left_ms         = left_cur;

      unique case (in_req.op)
         OP_LOGIN: begin
            dec_in.authenticated = live;
            if (rate_hit) begin
               dec_in.status = ST_RATE;
            end else begin
               last_login_in = in_req.now_ms;
               if (in_force) begin
                  dec_in.status = ST_LOCKED;
               end else if (in_req.password_ok) begin
                  session_client_in    = in_req.client_id;
                  last_activity_in     = in_req.now_ms;
                  fail_count_in        = 8'd0;
                  lock_valid_in        = 1'b0;
                  lockout_length_in    = cfg.base_lockout;
                  dec_in.authenticated = in_req.client_id != 32'd0;
               end else begin
                  dec_in.status = ST_BADPASS;
                  lock_valid_in = 1'b0;
                  fail_count_in = fc_inc;
                  if (trip) begin
                     lock_start_in        = in_req.now_ms;
                     lock_span_in         = lockout_length_ff;
                     lockout_length_in    = grown_sat;
                     dec_in.lockout_began = 1'b1;
                     dec_in.left_ms       = lockout_length_ff;
                     // A zero-length lockout runs out at once and clears the count
                     if (lockout_length_ff != 32'd0) begin
                        lock_valid_in = 1'b1;
                     end else begin
                        fail_count_in = 8'd0;
                     end
                  end
               end
            end
         end
         OP_LOGOUT: begin
            if (match) begin
               session_client_in = 32'd0;
               last_activity_in  = 32'd0;
            end else begin
               dec_in.status = ST_NOAUTH;
            end
         end
         OP_STATUS: begin
            if (lock_expired) begin
               lock_valid_in = 1'b0;
               fail_count_in = 8'd0;
            end
            if (!in_force && match) begin
               if (live) begin
                  dec_in.authenticated = 1'b1;
               end else begin
                  session_client_in = 32'd0;
               end
            end
         end
         OP_ACCESS: begin
            if (live) begin
               last_activity_in     = in_req.now_ms;
               dec_in.authenticated = 1'b1;
            end else begin
               dec_in.status = ST_NOAUTH;
               if (match) begin
                  session_client_in = 32'd0;
               end
            end
         end
      endcase

      dec_in.failed_attempts = fail_count_in;
      dec_in.locked          = dec_in.left_ms != 32'd0;
   end

   // Hold state; advance it and the decision register on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         fail_count_ff     <= 8'd0;
         lock_start_ff     <= 32'd0;
         lock_span_ff      <= 32'd0;
         lock_valid_ff     <= 1'b0;
         lockout_length_ff <= RST_BASE_LOCKOUT;
         last_login_ff     <= 32'd0;
         session_client_ff <= 32'd0;
         last_activity_ff  <= 32'd0;
         dec_valid_ff      <= 1'b0;
      end else begin
         if (take) begin
            fail_count_ff     <= fail_count_in;
            lock_start_ff     <= lock_start_in;
            lock_span_ff      <= lock_span_in;
            lock_valid_ff     <= lock_valid_in;
            lockout_length_ff <= lockout_length_in;
            last_login_ff     <= last_login_in;
            session_client_ff <= session_client_in;
            last_activity_ff  <= last_activity_in;
         end
         if (in_ready) begin
            dec_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dec_ff <= dec_in;
      end
   end

   assign dec_valid = dec_valid_ff;
   assign dec       = dec_ff;

endmodule

`default_nettype wire

>>> rtl/llsg_div.sv
// Output stage of the login guard: lockout time in seconds and the result register.
// Divides by 1000 through a reciprocal multiply. Depends on llsg_pkg.
`default_nettype none

module llsg_div
   import llsg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         dec_valid,
   input  wire decision_type dec,
   output logic              dec_ready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata
);

   logic             rsp_valid_ff;
   logic [39:0]      rsp_data_ff, rsp_data_in;
   logic [60:0]      prod;
   logic [REM_W-1:0] rem_sec;

   assign dec_ready = !rsp_valid_ff || rsp_tready;

   // Exact quotient of a 32-bit value by 1000
   always_comb begin
      prod        = {29'd0, dec.left_ms} * {32'd0, DIV1000_MULT};
      rem_sec     = prod[DIV1000_SHIFT +: REM_W];
      rsp_data_in = {3'd0, dec.lockout_began, dec.failed_attempts, rem_sec,
                     dec.locked, dec.authenticated, dec.status};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dec_ready) begin
         rsp_valid_ff <= dec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_ready && dec_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/login_lockout_session_guard.sv
// Login lockout and session guard, top level.
// An accepted request passes the input register, the decision register and the
// output register on its way to the response. Throughput: one transaction per
// cycle while rsp_tready is high; the decision stage reads the guard state and
// rewrites it in the same cycle. Reset (synchronous, active high) empties the
// stages, clears the guard state and restores the config registers to defaults.
`default_nettype none

module login_lockout_session_guard
   import llsg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [71:0]           req_tdata,  // now_ms, client_id, password_ok, zero pad
   input  wire logic [1:0]            req_tuser,  // op
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status, authenticated, locked, remaining_seconds, failed_attempts,
   // lockout_began, zero pad
   output logic [39:0]                rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   logic         in_valid_ff;
   req_type      in_req_ff, in_req_in;
   logic         core_ready;
   logic         dec_valid, dec_ready;
   decision_type dec;
   logic         req_take;

   assign req_tready = !in_valid_ff || core_ready;
   assign req_take   = req_tvalid && req_tready;

   // Unpack the request transaction
   always_comb begin
      in_req_in.op          = op_type'(req_tuser);
      in_req_in.now_ms      = req_tdata[31:0];
      in_req_in.client_id   = req_tdata[63:32];
      in_req_in.password_ok = req_tdata[64];
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= in_req_in;
      end
   end

   llsg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   llsg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_req    (in_req_ff),
      .in_ready  (core_ready),
      .dec_valid (dec_valid),
      .dec       (dec),
      .dec_ready (dec_ready)
   );

   llsg_div u_div (
      .clock      (clock),
      .reset      (reset),
      .dec_valid  (dec_valid),
      .dec        (dec),
      .dec_ready  (dec_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
